// ===== hw/rtl/rgb_led_effect_engine_unit_defines.svh =====
// Assertion macros shared by the LED effect engine RTL.
`ifndef RGB_LED_EFFECT_ENGINE_UNIT_DEFINES_SVH
`define RGB_LED_EFFECT_ENGINE_UNIT_DEFINES_SVH

// Checked only outside reset.
`define REE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define REE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ree_pkg.sv =====
// Types, register indexes and pattern tables of the LED effect engine.
package ree_pkg;

  localparam int unsigned LED_COUNT = 3;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned CFG_W     = 24;

  typedef logic [COLOR_W-1:0]   color_t;
  typedef logic [TIMER_W-1:0]   timer_t;
  typedef logic [LED_COUNT-1:0] led_mask_t;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_QUICK    = 3'd1,
    MODE_SLOW     = 3'd2,
    MODE_FADE     = 3'd3,
    MODE_BREATH   = 3'd4,
    MODE_STATIC   = 3'd5,
    MODE_BOUNCING = 3'd6,
    MODE_FILLING  = 3'd7
  } mode_t;

  // Register 7 is unused: writes there are ignored.
  typedef enum logic [2:0] {
    REG_EFFECT_MODE     = 3'd0,
    REG_BASE_COLOR      = 3'd1,
    REG_BREATH_INC      = 3'd2,
    REG_RAMP_PERIOD     = 3'd3,
    REG_RAMP_STEPS      = 3'd4,
    REG_BLINK_HALF      = 3'd5,
    REG_PATTERN_INTERVAL = 3'd6,
    REG_UNUSED          = 3'd7
  } reg_index_t;

  localparam logic [2:0] BOUNCE_LAST = 3'd3;
  localparam logic [2:0] FILL_LAST   = 3'd5;
  localparam logic [2:0] FILL_FULL   = 3'd3;

  // Bouncing order 0,1,2,1 as one-hot masks.
  function automatic led_mask_t bounce_mask(input logic [1:0] phase);
    led_mask_t m;
    unique case (phase)
      2'd0:    m = 3'b001;
      2'd1:    m = 3'b010;
      2'd2:    m = 3'b100;
      default: m = 3'b010;
    endcase
    return m;
  endfunction

  // Fill then empty the row over six phases.
  function automatic led_mask_t fill_mask(input logic [2:0] phase);
    led_mask_t m;
    unique case (phase)
      3'd1:    m = 3'b001;
      3'd2:    m = 3'b011;
      3'd3:    m = 3'b111;
      3'd4:    m = 3'b110;
      3'd5:    m = 3'b100;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/rgb_led_effect_engine_unit.sv =====
// RGB LED effect engine: timers, ramp and pattern state, registered result.
//
// Usage: each request on the item channel (item_valid/item_stall) carries one
// tick bit; tick=1 means one millisecond has passed, tick=0 only asks for the
// current LED state. Every accepted request yields exactly one result on the
// result channel (result_valid/result_stall): three 24-bit LED colors, the on
// mask and the clean-switch boundary flag.
// Latency: the result is valid in the cycle after the request is accepted.
// Throughput: one request per cycle unless stalled; the state update and output
// decode sit between the state registers and the single result register.
// When the receiver stalls, the result register holds and item_stall rises,
// so no further request is taken until the result is accepted; a request is
// taken in the same cycle the waiting result leaves.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// ready and, save for register 7, restart the effect; issue them only while no
// result is pending. item_stall is also high while a write is offered, so no
// request is taken then. Reset (rst, synchronous) loads the default registers,
// clears all timers and flags and empties the result register.
`include "rgb_led_effect_engine_unit_defines.svh"

module rgb_led_effect_engine_unit (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic                       tick,
  // result channel
  output logic                       result_valid,
  input  logic                       result_stall,
  output ree_pkg::color_t            led0_color,
  output ree_pkg::color_t            led1_color,
  output ree_pkg::color_t            led2_color,
  output ree_pkg::led_mask_t         led_on_mask,
  output logic                       cycle_boundary,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [ree_pkg::CFG_W-1:0]  cfg_data
);

  // Configuration registers
  ree_pkg::mode_t  effect_mode;
  ree_pkg::color_t base_color;
  logic [6:0]      breath_increment;
  ree_pkg::timer_t ramp_period_ms;
  logic [7:0]      ramp_steps;
  ree_pkg::timer_t blink_half_period_ms;
  ree_pkg::timer_t pattern_interval_ms;

  // Effect state
  ree_pkg::color_t ramp_color,        ramp_color_next;
  logic [7:0]      ramp_step_index,   ramp_step_index_next;
  ree_pkg::timer_t effect_elapsed_ms, effect_elapsed_ms_next;
  ree_pkg::timer_t blink_elapsed_ms,  blink_elapsed_ms_next;
  logic            quick_flag,        quick_flag_next;
  logic            slow_flag,         slow_flag_next;
  logic [2:0]      pattern_phase,     pattern_phase_next;
  logic            boundary_flag,     boundary_flag_next;

  // Result decode
  ree_pkg::color_t    col0, col1, col2;
  ree_pkg::led_mask_t mask;
  logic               bound;

  logic item_accept;
  logic cfg_write;
  logic cfg_restart;

  assign item_stall  = (result_valid & result_stall) | cfg_valid;
  assign item_accept = item_valid & ~item_stall;
  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid & cfg_ready;
  assign cfg_restart = cfg_write &
                       (ree_pkg::reg_index_t'(cfg_index) != ree_pkg::REG_UNUSED);

  // Timers, ramp step and pattern phase for one request
  always_comb begin
    ree_pkg::timer_t blink_cnt;
    ree_pkg::timer_t eff_cnt;
    logic [8:0]      sum;
    logic [7:0]      ch;
    logic            rising;
    logic [7:0]      idx_inc;

    blink_elapsed_ms_next  = blink_elapsed_ms;
    quick_flag_next        = quick_flag;
    slow_flag_next         = slow_flag;
    effect_elapsed_ms_next = effect_elapsed_ms;
    ramp_color_next        = ramp_color;
    ramp_step_index_next   = ramp_step_index;
    pattern_phase_next     = pattern_phase;
    boundary_flag_next     = boundary_flag;
    blink_cnt = blink_elapsed_ms;
    eff_cnt   = effect_elapsed_ms;
    sum       = '0;
    ch        = '0;
    rising    = ramp_step_index < (ramp_steps >> 1);
    idx_inc   = ramp_step_index + 8'd1;

    if (tick) begin
      // blink timer, saturating
      if (blink_cnt != '1) blink_cnt = blink_cnt + 16'd1;
      if (blink_cnt >= blink_half_period_ms) begin
        blink_cnt       = '0;
        quick_flag_next = ~quick_flag;
        if (!quick_flag) slow_flag_next = ~slow_flag;
      end
      blink_elapsed_ms_next = blink_cnt;

      // effect timer, saturating
      if (eff_cnt != '1) eff_cnt = eff_cnt + 16'd1;
      effect_elapsed_ms_next = eff_cnt;

      if (effect_mode == ree_pkg::MODE_FADE || effect_mode == ree_pkg::MODE_BREATH) begin
        if (eff_cnt >= ramp_period_ms) begin
          effect_elapsed_ms_next = '0;
          // per-channel ramp, channels independent
          for (int i = 0; i < 3; i++) begin
            ch = ramp_color[i*8 +: 8];
            if (effect_mode == ree_pkg::MODE_FADE) begin
              ch = (ch >= 8'd2) ? ch - 8'd2 : 8'd0;
            end else if (base_color[i*8 +: 8] != 8'd0) begin
              sum = {1'b0, ch} + {2'b00, breath_increment};
              if (rising) begin
                if (sum <= 9'd255) ch = sum[7:0];
              end else if (ch >= {1'b0, breath_increment}) begin
                ch = ch - {1'b0, breath_increment};
              end
            end
            ramp_color_next[i*8 +: 8] = ch;
          end
          // step index and boundary
          if (effect_mode == ree_pkg::MODE_FADE) begin
            if (ramp_step_index < ramp_steps) begin
              ramp_step_index_next = idx_inc;
              boundary_flag_next   = 1'b0;
            end else begin
              boundary_flag_next   = 1'b1;
            end
          end else if (idx_inc >= ramp_steps) begin
            ramp_step_index_next = '0;
            boundary_flag_next   = 1'b1;
          end else begin
            ramp_step_index_next = idx_inc;
            boundary_flag_next   = 1'b0;
          end
        end
      end else if (effect_mode == ree_pkg::MODE_BOUNCING ||
                   effect_mode == ree_pkg::MODE_FILLING) begin
        if (eff_cnt >= pattern_interval_ms) begin
          effect_elapsed_ms_next = '0;
          if (effect_mode == ree_pkg::MODE_BOUNCING)
            pattern_phase_next = {1'b0, pattern_phase[1:0] + 2'd1};
          else
            pattern_phase_next = (pattern_phase >= ree_pkg::FILL_LAST) ? 3'd0
                                                                      : pattern_phase + 3'd1;
        end
      end
    end
  end

  // Output decode from the updated state
  always_comb begin
    logic [2:0] p;
    p     = (pattern_phase_next > ree_pkg::FILL_LAST) ? 3'd0 : pattern_phase_next;
    col0  = '0;
    col1  = '0;
    col2  = '0;
    mask  = '0;
    bound = 1'b1;
    unique case (effect_mode)
      ree_pkg::MODE_QUICK, ree_pkg::MODE_SLOW: begin
        col0  = base_color;
        col1  = base_color;
        col2  = base_color;
        bound = (effect_mode == ree_pkg::MODE_QUICK) ? quick_flag_next : slow_flag_next;
        mask  = {3{bound}};
      end
      ree_pkg::MODE_FADE, ree_pkg::MODE_BREATH: begin
        col0  = ramp_color_next;
        col1  = ramp_color_next;
        col2  = ramp_color_next;
        mask  = 3'b111;
        bound = boundary_flag_next;
      end
      ree_pkg::MODE_STATIC: begin
        col0 = base_color;
        col1 = base_color;
        col2 = base_color;
        mask = 3'b111;
      end
      ree_pkg::MODE_BOUNCING, ree_pkg::MODE_FILLING: begin
        if (effect_mode == ree_pkg::MODE_BOUNCING) begin
          mask = ree_pkg::bounce_mask(pattern_phase_next[1:0]);
        end else begin
          mask  = ree_pkg::fill_mask(p);
          bound = (p == ree_pkg::FILL_FULL);
        end
        col0 = mask[0] ? base_color : '0;
        col1 = mask[1] ? base_color : '0;
        col2 = mask[2] ? base_color : '0;
      end
      default: begin
      end
    endcase
  end

  // Configuration, state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode          <= ree_pkg::MODE_OFF;
      base_color           <= '0;
      breath_increment     <= 7'd3;
      ramp_period_ms       <= 16'd20;
      ramp_steps           <= 8'd120;
      blink_half_period_ms <= 16'd250;
      pattern_interval_ms  <= 16'd500;
      ramp_color           <= '0;
      ramp_step_index      <= '0;
      effect_elapsed_ms    <= '0;
      blink_elapsed_ms     <= '0;
      quick_flag           <= 1'b0;
      slow_flag            <= 1'b0;
      pattern_phase        <= '0;
      boundary_flag        <= 1'b0;
      result_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_restart) begin
          // any write but to the unused index restarts the effect
          ramp_color        <= base_color;
          ramp_step_index   <= '0;
          effect_elapsed_ms <= '0;
          pattern_phase     <= '0;
          boundary_flag     <= 1'b0;
        end
        unique case (ree_pkg::reg_index_t'(cfg_index))
          ree_pkg::REG_EFFECT_MODE:      effect_mode <= ree_pkg::mode_t'(cfg_data[2:0]);
          ree_pkg::REG_BASE_COLOR: begin
            base_color <= cfg_data[23:0];
            ramp_color <= cfg_data[23:0];
          end
          ree_pkg::REG_BREATH_INC:       breath_increment     <= cfg_data[6:0];
          ree_pkg::REG_RAMP_PERIOD:      ramp_period_ms       <= cfg_data[15:0];
          ree_pkg::REG_RAMP_STEPS:       ramp_steps           <= cfg_data[7:0];
          ree_pkg::REG_BLINK_HALF:       blink_half_period_ms <= cfg_data[15:0];
          ree_pkg::REG_PATTERN_INTERVAL: pattern_interval_ms  <= cfg_data[15:0];
          default: begin
          end
        endcase
      end else if (item_accept) begin
        ramp_color        <= ramp_color_next;
        ramp_step_index   <= ramp_step_index_next;
        effect_elapsed_ms <= effect_elapsed_ms_next;
        blink_elapsed_ms  <= blink_elapsed_ms_next;
        quick_flag        <= quick_flag_next;
        slow_flag         <= slow_flag_next;
        pattern_phase     <= pattern_phase_next;
        boundary_flag     <= boundary_flag_next;
      end
      if (item_accept && !cfg_write) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded on each accepted request
  always_ff @(posedge clk) begin
    if (item_accept && !cfg_write) begin
      led0_color     <= col0;
      led1_color     <= col1;
      led2_color     <= col2;
      led_on_mask    <= mask;
      cycle_boundary <= bound;
    end
  end

  `REE_ASSERT(a_result_follows, item_accept |=> result_valid, "request without result")
  `REE_ASSERT(a_result_drains, result_valid && !result_stall && !item_accept |=> !result_valid, "result repeated")
  `REE_ASSERT(a_cfg_restart, cfg_restart |=> effect_elapsed_ms == '0 && pattern_phase == '0, "restart missed")
  `REE_ASSERT_ALWAYS(a_phase_range, rst || pattern_phase <= ree_pkg::FILL_LAST, "phase out of range")

endmodule

// ===== dv/tb_rgb_led_effect_engine_unit.sv =====
// Self-checking testbench for the RGB LED effect engine: random tick requests against a predictor.
module tb_rgb_led_effect_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1350;
  localparam int unsigned CALM_FROM   = 1150;

  // One LED frame as reported on the result channel
  typedef struct packed {
    ree_pkg::color_t    led0;
    ree_pkg::color_t    led1;
    ree_pkg::color_t    led2;
    ree_pkg::led_mask_t on_mask;
    logic               boundary;
  } led_frame_t;

  // Bouncing order 0,1,2,1 and the six fill/empty phases
  localparam ree_pkg::led_mask_t BOUNCE_ORDER [4] = '{3'b001, 3'b010, 3'b100, 3'b010};
  localparam ree_pkg::led_mask_t FILL_ORDER   [6] =
    '{3'b000, 3'b001, 3'b011, 3'b111, 3'b110, 3'b100};

  class led_frame_scoreboard;
    // register copy
    ree_pkg::mode_t   mode;
    ree_pkg::color_t  base;
    logic [6:0]       inc;
    ree_pkg::timer_t  ramp_period;
    logic [7:0]       steps;
    ree_pkg::timer_t  blink_half;
    ree_pkg::timer_t  interval;
    // effect state
    ree_pkg::color_t  ramp_color;
    logic [7:0]       step_idx;
    ree_pkg::timer_t  effect_ms;
    ree_pkg::timer_t  blink_ms;
    bit               quick;
    bit               slow;
    logic [2:0]       phase;
    bit               bound_flag;

    led_frame_t   pending_frames[$];
    int unsigned  errors;
    int unsigned  frames_seen;

    function new();
      mode        = ree_pkg::MODE_OFF;
      base        = '0;
      inc         = 7'd3;
      ramp_period = 16'd20;
      steps       = 8'd120;
      blink_half  = 16'd250;
      interval    = 16'd500;
      blink_ms    = '0;
      quick       = 1'b0;
      slow        = 1'b0;
      errors      = 0;
      frames_seen = 0;
      restart();
    endfunction

    function void restart();
      ramp_color = base;
      step_idx   = '0;
      effect_ms  = '0;
      phase      = '0;
      bound_flag = 1'b0;
    endfunction

    // Register write; the unused index leaves everything alone
    function void apply_write(ree_pkg::reg_index_t idx, logic [23:0] data);
      case (idx)
        ree_pkg::REG_EFFECT_MODE:      mode        = ree_pkg::mode_t'(data[2:0]);
        ree_pkg::REG_BASE_COLOR:       base        = data;
        ree_pkg::REG_BREATH_INC:       inc         = data[6:0];
        ree_pkg::REG_RAMP_PERIOD:      ramp_period = data[15:0];
        ree_pkg::REG_RAMP_STEPS:       steps       = data[7:0];
        ree_pkg::REG_BLINK_HALF:       blink_half  = data[15:0];
        ree_pkg::REG_PATTERN_INTERVAL: interval    = data[15:0];
        default:                       return;
      endcase
      restart();
    endfunction

    // One fade or breath step on all three channels
    function void advance_ramp();
      ree_pkg::color_t nxt;
      logic [8:0]      c;
      for (int k = 0; k < 3; k++) begin
        c = {1'b0, ramp_color[8*k +: 8]};
        if (mode == ree_pkg::MODE_FADE) begin
          c = (c >= 2) ? c - 9'd2 : 9'd0;
        end else if (base[8*k +: 8] != 8'd0) begin
          if (step_idx < (steps >> 1)) begin
            if (c + inc <= 255) c = c + inc;
          end else if (c >= inc) begin
            c = c - inc;
          end
        end
        nxt[8*k +: 8] = c[7:0];
      end
      ramp_color = nxt;
      if (mode == ree_pkg::MODE_FADE) begin
        if (step_idx < steps) begin
          step_idx++;
          bound_flag = 1'b0;
        end else begin
          bound_flag = 1'b1;
        end
      end else begin
        step_idx = step_idx + 8'd1;
        if (step_idx >= steps) begin
          step_idx   = '0;
          bound_flag = 1'b1;
        end else begin
          bound_flag = 1'b0;
        end
      end
    endfunction

    // Advance on an accepted request and queue the frame it should produce
    function void note_request(bit t);
      led_frame_t f;
      bit         flag;
      logic [2:0] p;
      if (t) begin
        if (blink_ms != 16'hFFFF) blink_ms++;
        if (blink_ms >= blink_half) begin
          blink_ms = '0;
          quick    = ~quick;
          if (quick) slow = ~slow;
        end
        if (effect_ms != 16'hFFFF) effect_ms++;
        if (mode == ree_pkg::MODE_FADE || mode == ree_pkg::MODE_BREATH) begin
          if (effect_ms >= ramp_period) begin
            effect_ms = '0;
            advance_ramp();
          end
        end else if (mode == ree_pkg::MODE_BOUNCING || mode == ree_pkg::MODE_FILLING) begin
          if (effect_ms >= interval) begin
            effect_ms = '0;
            if (mode == ree_pkg::MODE_BOUNCING) phase = (phase + 3'd1) & ree_pkg::BOUNCE_LAST;
            else phase = (phase >= ree_pkg::FILL_LAST) ? 3'd0 : phase + 3'd1;
          end
        end
      end

      f          = '0;
      f.boundary = 1'b1;
      case (mode)
        ree_pkg::MODE_QUICK, ree_pkg::MODE_SLOW: begin
          flag       = (mode == ree_pkg::MODE_QUICK) ? quick : slow;
          f.led0     = base;
          f.led1     = base;
          f.led2     = base;
          f.on_mask  = flag ? 3'b111 : 3'b000;
          f.boundary = flag;
        end
        ree_pkg::MODE_FADE, ree_pkg::MODE_BREATH: begin
          f.led0     = ramp_color;
          f.led1     = ramp_color;
          f.led2     = ramp_color;
          f.on_mask  = 3'b111;
          f.boundary = bound_flag;
        end
        ree_pkg::MODE_STATIC: begin
          f.led0    = base;
          f.led1    = base;
          f.led2    = base;
          f.on_mask = 3'b111;
        end
        ree_pkg::MODE_BOUNCING: begin
          f.on_mask = BOUNCE_ORDER[phase[1:0]];
        end
        ree_pkg::MODE_FILLING: begin
          p          = (phase > ree_pkg::FILL_LAST) ? 3'd0 : phase;
          f.on_mask  = FILL_ORDER[p];
          f.boundary = (p == ree_pkg::FILL_FULL);
        end
        default: ;
      endcase
      // pattern modes light only the masked LEDs
      if (mode == ree_pkg::MODE_BOUNCING || mode == ree_pkg::MODE_FILLING) begin
        f.led0 = f.on_mask[0] ? base : '0;
        f.led1 = f.on_mask[1] ? base : '0;
        f.led2 = f.on_mask[2] ? base : '0;
      end
      pending_frames.push_back(f);
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $error("%s: expected %06h, actual %06h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(led_frame_t got);
      led_frame_t want;
      frames_seen++;
      if (pending_frames.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      compare_field("led0_color", want.led0, got.led0);
      compare_field("led1_color", want.led1, got.led1);
      compare_field("led2_color", want.led2, got.led2);
      compare_field("led_on_mask", 24'(want.on_mask), 24'(got.on_mask));
      compare_field("cycle_boundary", 24'(want.boundary), 24'(got.boundary));
    endfunction
  endclass

  logic                      clk;
  logic                      rst          = 1'b1;
  logic                      item_valid   = 1'b0;
  logic                      item_stall;
  logic                      tick         = 1'b0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  ree_pkg::color_t           led0_color;
  ree_pkg::color_t           led1_color;
  ree_pkg::color_t           led2_color;
  ree_pkg::led_mask_t        led_on_mask;
  logic                      cycle_boundary;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [2:0]                cfg_index    = '0;
  logic [ree_pkg::CFG_W-1:0] cfg_data     = '0;

  led_frame_scoreboard sb = new();
  int unsigned idle_pct   = 0;
  int unsigned stall_left = 0;
  int unsigned n_items    = 0;
  int unsigned n_settings = 0;

  rgb_led_effect_engine_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .tick           (tick),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .led0_color     (led0_color),
    .led1_color     (led1_color),
    .led2_color     (led2_color),
    .led_on_mask    (led_on_mask),
    .cycle_boundary (cycle_boundary),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
      if ($urandom_range(99) < idle_pct) stall_left = $urandom_range(1, 3);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result({led0_color, led1_color, led2_color, led_on_mask, cycle_boundary});
  end

  // Send one tick request, then maybe leave a gap
  task automatic drive_item(input bit t);
    cfg_valid  <= 1'b0;
    item_valid <= 1'b1;
    tick       <= t;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_request(t);
    n_items++;
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Register write; cfg_valid is dropped by the next request
  task automatic cfg_write(input ree_pkg::reg_index_t idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_write(idx, data);
  endtask

  // Stop requesting and wait until every result is back
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_frames.size() != 0) @(posedge clk);
  endtask

  // Random junk above a register's width
  function automatic logic [23:0] with_noise(logic [23:0] value, int unsigned width);
    return value | (24'($urandom) << width);
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(19))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [7:0] pick_steps();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [6:0] pick_inc();
    case ($urandom_range(5))
      0:       return 7'd0;
      1:       return 7'd127;
      default: return 7'($urandom);
    endcase
  endfunction

  function automatic ree_pkg::color_t pick_color();
    ree_pkg::color_t c;
    case ($urandom_range(7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: begin
        c = 24'($urandom);
        // knock out channels so breath skips them
        for (int k = 0; k < 3; k++)
          if ($urandom_range(3) == 0) c[8*k +: 8] = 8'h00;
        return c;
      end
    endcase
  endfunction

  // New random setting; the mode is always rewritten
  task automatic apply_random_setting();
    if ($urandom_range(9) < 4) cfg_write(ree_pkg::REG_BASE_COLOR, pick_color());
    if ($urandom_range(9) < 4)
      cfg_write(ree_pkg::REG_BREATH_INC, with_noise(24'(pick_inc()), 7));
    if ($urandom_range(9) < 4)
      cfg_write(ree_pkg::REG_RAMP_PERIOD, with_noise(24'(pick_period()), 16));
    if ($urandom_range(9) < 4)
      cfg_write(ree_pkg::REG_RAMP_STEPS, with_noise(24'(pick_steps()), 8));
    if ($urandom_range(9) < 4)
      cfg_write(ree_pkg::REG_BLINK_HALF, with_noise(24'(pick_period()), 16));
    if ($urandom_range(9) < 4)
      cfg_write(ree_pkg::REG_PATTERN_INTERVAL, with_noise(24'(pick_period()), 16));
    cfg_write(ree_pkg::REG_EFFECT_MODE, with_noise(24'($urandom_range(7)), 3));
    if ($urandom_range(9) == 0) cfg_write(ree_pkg::REG_UNUSED, 24'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 20;

    // defaults: off mode
    drive_item(1'b0);
    drive_item(1'b1);

    // fade from white, one step per tick, single-step ramp
    settle();
    cfg_write(ree_pkg::REG_EFFECT_MODE, 24'(ree_pkg::MODE_FADE));
    cfg_write(ree_pkg::REG_BASE_COLOR, 24'hFFFFFF);
    cfg_write(ree_pkg::REG_BREATH_INC, 24'h00007F);
    cfg_write(ree_pkg::REG_RAMP_PERIOD, 24'h000000);
    cfg_write(ree_pkg::REG_RAMP_STEPS, 24'h000001);
    cfg_write(ree_pkg::REG_BLINK_HALF, 24'h000001);
    cfg_write(ree_pkg::REG_PATTERN_INTERVAL, 24'h00FFFF);
    drive_item(1'b1);
    drive_item(1'b1);
    drive_item(1'b1);

    // breath with a saturation skip on red only, green held at zero
    settle();
    cfg_write(ree_pkg::REG_BASE_COLOR, 24'h800001);
    cfg_write(ree_pkg::REG_RAMP_PERIOD, 24'h000001);
    cfg_write(ree_pkg::REG_RAMP_STEPS, 24'h000004);
    cfg_write(ree_pkg::REG_EFFECT_MODE, 24'(ree_pkg::MODE_BREATH));
    repeat (5) drive_item(1'b1);
    // zero steps: boundary on every step
    settle();
    cfg_write(ree_pkg::REG_RAMP_STEPS, 24'h000000);
    drive_item(1'b1);
    drive_item(1'b1);
    // write to the unused index must not restart anything
    settle();
    cfg_write(ree_pkg::REG_UNUSED, 24'hFFFFFF);
    drive_item(1'b1);

    // blink modes: quick toggles every tick, slow every other tick
    settle();
    cfg_write(ree_pkg::REG_EFFECT_MODE, 24'(ree_pkg::MODE_QUICK));
    drive_item(1'b1);
    drive_item(1'b1);
    settle();
    cfg_write(ree_pkg::REG_EFFECT_MODE, 24'(ree_pkg::MODE_SLOW));
    drive_item(1'b1);
    drive_item(1'b0);
    drive_item(1'b1);

    settle();
    cfg_write(ree_pkg::REG_EFFECT_MODE, 24'(ree_pkg::MODE_STATIC));
    drive_item(1'b1);

    // patterns: one phase per tick, zero interval for filling
    settle();
    cfg_write(ree_pkg::REG_PATTERN_INTERVAL, 24'h000001);
    cfg_write(ree_pkg::REG_EFFECT_MODE, 24'(ree_pkg::MODE_BOUNCING));
    repeat (4) drive_item(1'b1);
    settle();
    cfg_write(ree_pkg::REG_PATTERN_INTERVAL, 24'h000000);
    cfg_write(ree_pkg::REG_EFFECT_MODE, 24'(ree_pkg::MODE_FILLING));
    repeat (6) drive_item(1'b1);

    // random settings, each followed by a burst of requests
    while (n_items < ITEM_TARGET) begin
      settle();
      if (n_items >= CALM_FROM) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 35;
        endcase
      end
      apply_random_setting();
      n_settings++;
      repeat ($urandom_range(20, 60)) drive_item($urandom_range(99) < 85);
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Ran %0d tick requests (%0d results checked) across %0d random settings",
             n_items, sb.frames_seen, n_settings);
    $display("plus directed fade, breath, blink, static and pattern sequences");
    if (sb.errors == 0) begin
      $display("rgb_led_effect_engine_unit: match");
    end else begin
      $display("rgb_led_effect_engine_unit: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("rgb_led_effect_engine_unit: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ree_pkg.sv
hw/rtl/rgb_led_effect_engine_unit.sv
dv/tb_rgb_led_effect_engine_unit.sv
